### src/rvd_pkg.sv
// rvd_pkg: shared types and constants of the radial vignette / desaturate block
// used by every module under src but rvd_checker; depends on nothing
package rvd_pkg;

    localparam int CH_BITS   = 8;
    localparam int REG_BITS  = 13;
    localparam int Q_BITS    = 32;
    localparam int ROOT_BITS = 16;
    localparam int D_BITS    = 17;

    localparam logic [D_BITS-1:0] ONE_16      = 17'd65536;
    localparam logic [D_BITS-1:0] GAIN_MAX_16 = 17'd78643;
    // floor(n/3) == (n*683) >> 11 for n below 2048
    localparam logic [10:0]       DIV3_RECIP  = 11'd683;

    // how the distance is settled
    localparam logic [1:0] DC_CALC = 2'd0;
    localparam logic [1:0] DC_ZERO = 2'd1;
    localparam logic [1:0] DC_FULL = 2'd2;

    localparam int                  CFG_IDX_BITS = 4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 4'd1;

    typedef logic [1:0] t_dcode;

    typedef struct packed {
        logic [CH_BITS-1:0] blue;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic   valid;
        t_dcode code;
    } t_ctl;

endpackage

### src/rvd_norm_dist.sv
// rvd_norm_dist: squared center distance and restoring divider, one quotient bit a stage
// gives floor(S * 2^32 / T) while S < T; depends on rvd_pkg
module rvd_norm_dist #(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [COORD_BITS-1:0]         i_x,
    input  logic [COORD_BITS-1:0]         i_y,
    input  rvd_pkg::t_rgb                 i_rgb,
    input  logic [rvd_pkg::REG_BITS-1:0]  i_width,
    input  logic [rvd_pkg::REG_BITS-1:0]  i_height,
    output rvd_pkg::t_ctl                 o_ctl,
    output logic [rvd_pkg::Q_BITS-1:0]    o_quot,
    output rvd_pkg::t_rgb                 o_rgb
);
    import rvd_pkg::*;

    localparam int DW   = (COORD_BITS + 1 > REG_BITS) ? COORD_BITS + 1 : REG_BITS;
    localparam int SW   = 2 * DW + 1;
    localparam int NDIV = Q_BITS;

    logic [DW-1:0] n_wext, n_hext, n_x2, n_y2, n_dx, n_dy;
    logic          r_f1_valid;
    logic [DW-1:0] r_f1_dx, r_f1_dy;
    t_rgb          r_f1_rgb;

    logic                    r_f2_valid;
    logic [2*DW-1:0]         r_f2_sqx, r_f2_sqy;
    logic [2*REG_BITS-1:0]   r_f2_sqw, r_f2_sqh;
    t_rgb                    r_f2_rgb;

    logic [SW-1:0] n_s, n_t;
    t_dcode        n_code;
    t_ctl          r_f3_ctl;
    logic [SW-1:0] r_f3_rem, r_f3_den;
    t_rgb          r_f3_rgb;

    t_ctl              r_dv_ctl  [NDIV];
    logic [SW-1:0]     r_dv_rem  [NDIV];
    logic [SW-1:0]     r_dv_den  [NDIV];
    logic [Q_BITS-1:0] r_dv_quot [NDIV];
    t_rgb              r_dv_rgb  [NDIV];

    always_comb begin
        n_wext = DW'(i_width);
        n_hext = DW'(i_height);
        n_x2   = DW'({i_x, 1'b0});
        n_y2   = DW'({i_y, 1'b0});
        n_dx   = (n_wext >= n_x2) ? n_wext - n_x2 : n_x2 - n_wext;
        n_dy   = (n_hext >= n_y2) ? n_hext - n_y2 : n_y2 - n_hext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_ctl   <= '0;
        end else if (i_en) begin
            r_f1_valid <= i_valid;
            r_f2_valid <= r_f1_valid;
            r_f3_ctl   <= '{valid: r_f2_valid, code: n_code};
        end
    end

    always_comb begin
        n_s = SW'(r_f2_sqx) + SW'(r_f2_sqy);
        n_t = SW'(r_f2_sqw) + SW'(r_f2_sqh);
        if (n_t == '0) begin
            n_code = (n_s == '0) ? DC_ZERO : DC_FULL;
        end else begin
            n_code = (n_s >= n_t) ? DC_FULL : DC_CALC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_dx  <= n_dx;
            r_f1_dy  <= n_dy;
            r_f1_rgb <= i_rgb;
            r_f2_sqx <= (2*DW)'(r_f1_dx) * (2*DW)'(r_f1_dx);
            r_f2_sqy <= (2*DW)'(r_f1_dy) * (2*DW)'(r_f1_dy);
            r_f2_sqw <= (2*REG_BITS)'(i_width) * (2*REG_BITS)'(i_width);
            r_f2_sqh <= (2*REG_BITS)'(i_height) * (2*REG_BITS)'(i_height);
            r_f2_rgb <= r_f1_rgb;
            r_f3_rem <= (n_code == DC_CALC) ? n_s : '0;
            r_f3_den <= n_t;
            r_f3_rgb <= r_f2_rgb;
        end
    end

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        t_ctl              a_ctl;
        logic [SW-1:0]     a_rem, a_den;
        logic [Q_BITS-1:0] a_quot;
        t_rgb              a_rgb;
        logic [SW:0]       n_dbl;
        logic              n_ge;

        if (k == 0) begin : g_first
            assign a_ctl  = r_f3_ctl;
            assign a_rem  = r_f3_rem;
            assign a_den  = r_f3_den;
            assign a_quot = '0;
            assign a_rgb  = r_f3_rgb;
        end else begin : g_next
            assign a_ctl  = r_dv_ctl[k-1];
            assign a_rem  = r_dv_rem[k-1];
            assign a_den  = r_dv_den[k-1];
            assign a_quot = r_dv_quot[k-1];
            assign a_rgb  = r_dv_rgb[k-1];
        end

        assign n_dbl = {a_rem, 1'b0};
        assign n_ge  = n_dbl >= {1'b0, a_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_ctl[k] <= '0;
            end else if (i_en) begin
                r_dv_ctl[k] <= a_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_rem[k]  <= n_ge ? SW'(n_dbl - {1'b0, a_den}) : n_dbl[SW-1:0];
                r_dv_den[k]  <= a_den;
                r_dv_quot[k] <= {a_quot[Q_BITS-2:0], n_ge};
                r_dv_rgb[k]  <= a_rgb;
            end
        end
    end

    assign o_ctl  = r_dv_ctl[NDIV-1];
    assign o_quot = r_dv_quot[NDIV-1];
    assign o_rgb  = r_dv_rgb[NDIV-1];

endmodule

### src/rvd_isqrt.sv
// rvd_isqrt: digit-recurrence integer square root, one root bit a stage
// turns the quotient into the 1.16 distance; depends on rvd_pkg
module rvd_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  rvd_pkg::t_ctl                 i_ctl,
    input  logic [rvd_pkg::Q_BITS-1:0]    i_quot,
    input  rvd_pkg::t_rgb                 i_rgb,
    output logic                          o_valid,
    output logic [rvd_pkg::D_BITS-1:0]    o_dist,
    output rvd_pkg::t_rgb                 o_rgb
);
    import rvd_pkg::*;

    localparam int TW = Q_BITS + 2;

    t_ctl                 r_sq_ctl  [ROOT_BITS];
    logic [Q_BITS-1:0]    r_sq_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_sq_root [ROOT_BITS];
    t_rgb                 r_sq_rgb  [ROOT_BITS];

    for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sq
        localparam int B = ROOT_BITS - 1 - j;
        t_ctl                 a_ctl;
        logic [Q_BITS-1:0]    a_rem;
        logic [ROOT_BITS-1:0] a_root;
        t_rgb                 a_rgb;
        logic [TW-1:0]        n_trial;
        logic                 n_fit;

        if (j == 0) begin : g_first
            assign a_ctl  = i_ctl;
            assign a_rem  = i_quot;
            assign a_root = '0;
            assign a_rgb  = i_rgb;
        end else begin : g_next
            assign a_ctl  = r_sq_ctl[j-1];
            assign a_rem  = r_sq_rem[j-1];
            assign a_root = r_sq_root[j-1];
            assign a_rgb  = r_sq_rgb[j-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign n_trial = (TW'(a_root) << (B + 1)) + (TW'(1) << (2 * B));
        assign n_fit   = n_trial <= TW'(a_rem);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_ctl[j] <= '0;
            end else if (i_en) begin
                r_sq_ctl[j] <= a_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_rem[j]  <= n_fit ? Q_BITS'(TW'(a_rem) - n_trial) : a_rem;
                r_sq_root[j] <= n_fit ? (a_root | (ROOT_BITS'(1) << B)) : a_root;
                r_sq_rgb[j]  <= a_rgb;
            end
        end
    end

    always_comb begin
        case (r_sq_ctl[ROOT_BITS-1].code)
            DC_FULL: o_dist = ONE_16;
            DC_ZERO: o_dist = '0;
            default: o_dist = D_BITS'(r_sq_root[ROOT_BITS-1]);
        endcase
    end

    assign o_valid = r_sq_ctl[ROOT_BITS-1].valid;
    assign o_rgb   = r_sq_rgb[ROOT_BITS-1];

endmodule

### src/rvd_shade.sv
// rvd_shade: desaturation blend and vignette gain over four stages
// depends on rvd_pkg
module rvd_shade (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [rvd_pkg::D_BITS-1:0]    i_dist,
    input  rvd_pkg::t_rgb                 i_rgb,
    output logic                          o_valid,
    output rvd_pkg::t_rgb                 o_rgb
);
    import rvd_pkg::*;

    localparam int PW = 27;

    logic [2:0][CH_BITS-1:0] n_chan;
    logic [D_BITS-1:0]       n_inv, n_gain;
    logic [D_BITS:0]         n_graw;
    logic [9:0]              n_sum;

    logic                    r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic [2:0][PW-1:0]      r_s1_ma;
    logic [PW-1:0]           r_s1_mb;
    logic [D_BITS-1:0]       r_s1_gain, r_s2_gain, r_s3_gain;
    logic [2:0][9:0]         r_s2_hi;
    logic [2:0][CH_BITS-1:0] r_s3_v1;
    logic [2:0][CH_BITS-1:0] r_s4_out;

    always_comb begin
        n_chan = {i_rgb.blue, i_rgb.green, i_rgb.red};
        n_inv  = ONE_16 - i_dist;
        n_sum  = 10'(i_rgb.red) + 10'(i_rgb.green) + 10'(i_rgb.blue);
        n_graw = (D_BITS+1)'(GAIN_MAX_16) - (D_BITS+1)'(i_dist);
        n_gain = (n_graw > (D_BITS+1)'(ONE_16)) ? ONE_16 : n_graw[D_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_s1_ma[c]  <= PW'(n_inv) * (PW'(n_chan[c]) * PW'(3));
                // blend over 3*65536 = shift by 16, then divide by three
                r_s2_hi[c]  <= 10'((PW'(r_s1_ma[c]) + PW'(r_s1_mb)) >> 16);
                r_s3_v1[c]  <= CH_BITS'((20'(r_s2_hi[c]) * 20'(DIV3_RECIP)) >> 11);
                r_s4_out[c] <= CH_BITS'((25'(r_s3_v1[c]) * 25'(r_s3_gain)) >> 16);
            end
            r_s1_mb   <= PW'(i_dist) * PW'(n_sum);
            r_s1_gain <= n_gain;
            r_s2_gain <= r_s1_gain;
            r_s3_gain <= r_s2_gain;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_rgb   = '{blue: r_s4_out[2], green: r_s4_out[1], red: r_s4_out[0]};

endmodule

### src/radial_vignette_desaturate.sv
// radial_vignette_desaturate: top level, config registers, stall control
// depends on rvd_pkg, rvd_norm_dist, rvd_isqrt, rvd_shade
//
// Pixels come in on the s_axis request channel with their column and row and
// leave on m_axis with the three processed channels. The distance from the
// frame center sets a blend toward the pixel mean and a darkening gain.
// frame_width and frame_height are written on the cfg channel (index 0 and 1,
// other indexes are dropped); cfg_ready is always high, and the registers
// must only change while no pixel is in flight.
// A pixel passes the squared distance stages, the divider (one quotient
// bit per stage), the square root (one root bit per stage) and the blend
// and gain stages. One pixel per cycle is taken and given unless stalled.
// The whole pipeline moves on one enable: when the output holds a pixel the
// receiver has not taken, every stage freezes and s_axis_tready drops, so
// nothing is lost or repeated; bubbles are filled while the output is empty.
// Reset clears all stage valid bits and loads 1920 x 1080.
module radial_vignette_desaturate #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pix_x, pix_y, in_red, in_green, in_blue, zero fill
    input  logic [((2*COORD_BITS+24+7)/8)*8-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0]                       m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rvd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rvd_pkg::REG_BITS-1:0]      i_cfg_data
);
    import rvd_pkg::*;

    logic [REG_BITS-1:0]   r_width, r_height;
    logic                  n_en;
    logic [COORD_BITS-1:0] n_x, n_y;
    t_rgb                  n_rgb;

    t_ctl                  w_nd_ctl;
    logic [Q_BITS-1:0]     w_nd_quot;
    t_rgb                  w_nd_rgb;
    logic                  w_sq_valid;
    logic [D_BITS-1:0]     w_sq_dist;
    t_rgb                  w_sq_rgb;
    t_rgb                  w_out_rgb;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1920;
            r_height <= 13'd1080;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = n_en;

    assign n_x       = s_axis_tdata[COORD_BITS-1:0];
    assign n_y       = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign n_rgb     = t_rgb'(s_axis_tdata[2*COORD_BITS+23:2*COORD_BITS]);

    rvd_norm_dist #(
        .COORD_BITS(COORD_BITS)
    ) u_norm_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (n_en),
        .i_valid  (s_axis_tvalid),
        .i_x      (n_x),
        .i_y      (n_y),
        .i_rgb    (n_rgb),
        .i_width  (r_width),
        .i_height (r_height),
        .o_ctl    (w_nd_ctl),
        .o_quot   (w_nd_quot),
        .o_rgb    (w_nd_rgb)
    );

    rvd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (w_nd_ctl),
        .i_quot  (w_nd_quot),
        .i_rgb   (w_nd_rgb),
        .o_valid (w_sq_valid),
        .o_dist  (w_sq_dist),
        .o_rgb   (w_sq_rgb)
    );

    rvd_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (w_sq_valid),
        .i_dist  (w_sq_dist),
        .i_rgb   (w_sq_rgb),
        .o_valid (m_axis_tvalid),
        .o_rgb   (w_out_rgb)
    );

    assign m_axis_tdata = w_out_rgb;

endmodule

### src/rvd_checker.sv
// rvd_checker: port-level checks on the output channel and stall control
// bound to radial_vignette_desaturate; no package needed
module rvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output request dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow the output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output request right after reset");

endmodule

bind radial_vignette_desaturate rvd_checker u_rvd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### bench/tb_radial_vignette_desaturate.sv
// tb_radial_vignette_desaturate: self-checking bench for the radial vignette block
// depends on rvd_pkg and radial_vignette_desaturate; pixels stream in and out
// with random gaps and stalls, and each result is checked against a local model
`timescale 1ns / 100ps

module tb_radial_vignette_desaturate;
    import rvd_pkg::*;

    localparam int COORD_BITS = 12;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 4'd9;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [7:0]            r;
        logic [7:0]            g;
        logic [7:0]            b;
    } t_pix;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [REG_BITS-1:0]     i_cfg_data = '0;

    t_pix  pixel_queue[$];
    t_rgb  shaded_queue[$];
    int    fail_count = 0;
    bit    no_gaps = 1'b0;
    int    send_gap = 0;
    int    recv_gap = 0;
    bit    req_taken = 1'b0;
    logic [REG_BITS-1:0] frame_w = 13'd1920;
    logic [REG_BITS-1:0] frame_h = 13'd1080;

    radial_vignette_desaturate #(.COORD_BITS(COORD_BITS)) DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // exact integer blend and gain for one pixel at the current frame size
    function automatic t_rgb shade_pixel(t_pix p);
        logic [63:0] w, h, dx, dy, s, t, target, m, sum, v1, gain, d;
        logic [31:0] lo, hi, mid;
        logic [63:0] ch[3];
        t_rgb res;
        w = frame_w;
        h = frame_h;
        dx = (w >= 2 * p.x) ? w - 2 * p.x : 2 * p.x - w;
        dy = (h >= 2 * p.y) ? h - 2 * p.y : 2 * p.y - h;
        s = dx * dx + dy * dy;
        t = w * w + h * h;
        if (t == 0) begin
            d = (s == 0) ? 0 : 65536;
        end else if (s >= t) begin
            d = 65536;
        end else begin
            target = s << 32;
            lo = 0;
            hi = 65535;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                m = mid;
                if (m * m * t <= target) lo = mid;
                else hi = mid - 1;
            end
            d = lo;
        end
        ch[0] = p.r;
        ch[1] = p.g;
        ch[2] = p.b;
        sum = ch[0] + ch[1] + ch[2];
        gain = 78643 - d;
        if (gain > 65536) gain = 65536;
        for (int i = 0; i < 3; i++) begin
            v1 = ((65536 - d) * 3 * ch[i] + d * sum) / 196608;
            ch[i] = (v1 * gain) >> 16;
        end
        res.red = ch[0][7:0];
        res.green = ch[1][7:0];
        res.blue = ch[2][7:0];
        return res;
    endfunction

    // accepted pixel requests and returned results, sampled at the rising edge
    always @(posedge i_clk) begin
        t_rgb want, got;
        req_taken = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            shaded_queue.push_back(shade_pixel(pixel_queue.pop_front()));
            req_taken = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (shaded_queue.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = shaded_queue.pop_front();
                if (got.red !== want.red) begin
                    $error("out_red expected %0d actual %0d", want.red, got.red);
                    fail_count++;
                end
                if (got.green !== want.green) begin
                    $error("out_green expected %0d actual %0d", want.green, got.green);
                    fail_count++;
                end
                if (got.blue !== want.blue) begin
                    $error("out_blue expected %0d actual %0d", want.blue, got.blue);
                    fail_count++;
                end
            end
        end
    end

    // pixel driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (send_gap > 0 || pixel_queue.size() == 0) begin
                if (send_gap > 0) send_gap--;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {pixel_queue[0].b, pixel_queue[0].g, pixel_queue[0].r,
                                 pixel_queue[0].y, pixel_queue[0].x};
                send_gap = pick_gap();
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_WIDTH) frame_w = val;
        else if (idx == CFG_HEIGHT) frame_h = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0 || s_axis_tvalid || shaded_queue.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_chan();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'd0;
        if (roll == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_pixel(int x, int y, int r, int g, int b);
        t_pix p;
        p.x = COORD_BITS'(x);
        p.y = COORD_BITS'(y);
        p.r = 8'(r);
        p.g = 8'(g);
        p.b = 8'(b);
        pixel_queue.push_back(p);
    endtask

    task automatic add_random(int count);
        int xmax, ymax;
        xmax = (frame_w == 0) ? 0 : ((frame_w > 4096) ? 4095 : frame_w - 1);
        ymax = (frame_h == 0) ? 0 : ((frame_h > 4096) ? 4095 : frame_h - 1);
        for (int i = 0; i < count; i++) begin
            // mostly inside the frame, some anywhere in the coordinate range
            if ($urandom_range(0, 4) != 0)
                add_pixel($urandom_range(0, xmax), $urandom_range(0, ymax),
                          rand_chan(), rand_chan(), rand_chan());
            else
                add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                          rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    initial begin
        int widths[8];
        int heights[8];
        widths = '{1920, 1, 4096, 0, 8191, 640, 0, 7};
        heights = '{1080, 1, 4096, 0, 8191, 480, 5, 0};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size: center, corners, off frame, channel extremes
        add_pixel(960, 540, 200, 100, 50);
        add_pixel(0, 0, 255, 255, 255);
        add_pixel(1919, 1079, 255, 0, 0);
        add_pixel(0, 1079, 0, 255, 0);
        add_pixel(1919, 0, 0, 0, 255);
        add_pixel(4095, 4095, 255, 128, 0);
        add_pixel(4095, 0, 0, 0, 0);
        add_pixel(0, 4095, 255, 255, 255);
        add_pixel(961, 541, 17, 200, 99);
        add_pixel(2048, 1024, 170, 85, 255);
        add_pixel(480, 270, 1, 2, 3);
        add_pixel(1440, 810, 254, 127, 128);
        add_pixel(2730, 1365, 85, 170, 85);
        add_pixel(1, 1, 128, 128, 128);
        drain();
        // an unknown index must leave the size alone
        write_reg(CFG_UNUSED, 13'd17);

        for (int ph = 0; ph < 9; ph++) begin
            if (ph < 8) begin
                write_reg(CFG_WIDTH, REG_BITS'(widths[ph]));
                write_reg(CFG_HEIGHT, REG_BITS'(heights[ph]));
            end else begin
                write_reg(CFG_WIDTH, REG_BITS'($urandom_range(1, 8191)));
                write_reg(CFG_HEIGHT, REG_BITS'($urandom_range(1, 8191)));
            end
            no_gaps = (ph % 3 == 1);
            add_pixel(frame_w / 2, frame_h / 2, 255, 0, 128);
            add_pixel(0, 0, 0, 255, 128);
            add_random(160);
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_radial_vignette_desaturate passed");
        end else begin
            $display("tb_radial_vignette_desaturate failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_radial_vignette_desaturate failed");
        $finish;
    end

endmodule
